### rtl/uart_rx_stx_etx_deframer_macros.svh
// assertion macros used by the deframer top level
`ifndef UART_RX_STX_ETX_DEFRAMER_MACROS_SVH
`define UART_RX_STX_ETX_DEFRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define URXD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define URXD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/urxd_pkg.sv
// types and codes shared by the deframer modules
package urxd_pkg;

  localparam logic [7:0] STX_CODE = 8'h02;
  localparam logic [7:0] ETX_CODE = 8'h03;

  // line receiver phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HALF = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  // frame tracker states
  localparam logic [1:0] FS_WAIT    = 2'd0;
  localparam logic [1:0] FS_FRAME   = 2'd1;
  localparam logic [1:0] FS_PENDING = 2'd2;

  localparam int unsigned PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd104;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } byte_evt_t;

  typedef struct packed {
    logic data_valid;
    logic frame_start;
    logic frame_end;
    logic frame_pending;
  } frame_res_t;

endpackage

### rtl/urxd_in_if.sv
// input channel: one line sample and take request per transfer
interface urxd_in_if;
  logic valid;
  logic ready;
  logic rx_level;
  logic take_frame;

  modport source (output valid, output rx_level, output take_frame, input ready);
  modport sink   (input valid, input rx_level, input take_frame, output ready);
endinterface

### rtl/urxd_out_if.sv
// result channel: byte and frame flags per transfer
interface urxd_out_if;
  logic       valid;
  logic       ready;
  logic       byte_done;
  logic [7:0] byte_value;
  logic       data_valid;
  logic       frame_start;
  logic       frame_end;
  logic       frame_pending;

  modport source (output valid, output byte_done, output byte_value, output data_valid,
                  output frame_start, output frame_end, output frame_pending,
                  input ready);
  modport sink   (input valid, input byte_done, input byte_value, input data_valid,
                  input frame_start, input frame_end, input frame_pending,
                  output ready);
endinterface

### rtl/urxd_line_rx.sv
// bit-timed 8n1 line receiver, advanced one sample per step
module urxd_line_rx #(
  parameter int unsigned CNT_W = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic                                rx_level,
  input  logic [urxd_pkg::PERIOD_W-1:0]       bit_period,
  output urxd_pkg::byte_evt_t                 evt
);
  import urxd_pkg::*;

  localparam int unsigned WIDE_W = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
  localparam logic [WIDE_W-1:0] CNT_MAX = WIDE_W'({CNT_W{1'b1}});

  logic [1:0]            phase_r, phase_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic [7:0]            shift_r, shift_nxt;

  logic [PERIOD_W-1:0]   raw_tgt;
  logic [WIDE_W-1:0]     wide_tgt;
  logic [CNT_W-1:0]      tgt;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  hit;

  // half wait in the start bit, full period otherwise; saturate to counter range
  assign raw_tgt  = (phase_r == PH_HALF) ? (bit_period >> 1) : bit_period;
  assign wide_tgt = WIDE_W'(raw_tgt);
  assign tgt      = (wide_tgt > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(wide_tgt);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign hit      = (cnt_inc >= tgt);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    evt.done  = 1'b0;
    evt.value = 8'd0;
    case (phase_r)
      PH_IDLE: begin
        if (!rx_level) begin
          phase_nxt = PH_HALF;
          cnt_nxt   = '0;
          idx_nxt   = 3'd0;
          shift_nxt = 8'd0;
        end
      end
      PH_HALF: begin
        cnt_nxt = hit ? '0 : cnt_inc;
        if (hit) begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        cnt_nxt = hit ? '0 : cnt_inc;
        if (hit) begin
          shift_nxt = {rx_level, shift_r[7:1]};
          if (idx_r == 3'd7) begin
            idx_nxt   = 3'd0;
            phase_nxt = PH_STOP;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        // stop level is not checked
        cnt_nxt = hit ? '0 : cnt_inc;
        if (hit) begin
          phase_nxt = PH_IDLE;
          evt.done  = 1'b1;
          evt.value = shift_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      idx_r   <= 3'd0;
      shift_r <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

### rtl/urxd_framer.sv
// stx/etx frame tracker driven by received bytes
module urxd_framer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 take_frame,
  input  urxd_pkg::byte_evt_t  evt,
  output urxd_pkg::frame_res_t res
);
  import urxd_pkg::*;

  logic [1:0] fs_r, fs_nxt;
  logic [1:0] fs_cur;

  // a take acts on the state before this step's byte
  assign fs_cur = (take_frame && (fs_r == FS_PENDING)) ? FS_WAIT : fs_r;

  always_comb begin
    fs_nxt          = fs_cur;
    res.data_valid  = 1'b0;
    res.frame_start = 1'b0;
    res.frame_end   = 1'b0;
    if (evt.done) begin
      case (fs_cur)
        FS_FRAME: begin
          if (evt.value == ETX_CODE) begin
            fs_nxt        = FS_PENDING;
            res.frame_end = 1'b1;
          end else begin
            res.data_valid = 1'b1;
          end
        end
        FS_PENDING: begin
          // byte is swallowed
          fs_nxt = FS_WAIT;
        end
        default: begin
          if (evt.value == STX_CODE) begin
            fs_nxt          = FS_FRAME;
            res.frame_start = 1'b1;
          end else begin
            fs_nxt = FS_WAIT;
          end
        end
      endcase
    end
    res.frame_pending = (fs_nxt == FS_PENDING);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_WAIT;
    end else if (step) begin
      fs_r <= fs_nxt;
    end
  end

endmodule

### rtl/uart_rx_stx_etx_deframer.sv
// UART receiver with STX/ETX frame tracking, top level
//
// in_ch carries one sampled line level (rx_level) and a take request
// (take_frame) per transfer; each transfer is one bit-timing tick.
// out_ch returns exactly one result per accepted tick: byte_done and
// byte_value when a character completes, data_valid for frame payload,
// frame_start on STX, frame_end on ETX and frame_pending while a closed
// frame awaits a take.
// cfg_we/cfg_wdata write bit_period (ticks per bit); the user must do so
// only while the block is idle, which it does not enforce. An accepted
// tick's result is in the output register from the next cycle. One tick
// per cycle is taken while in_ch.ready is high, in one pass of the logic.
// in_ch.ready stays high while the output register is empty or being read,
// so a stalled receiver holds one result and stops intake after that.
// Reset returns the line to idle, the frame tracker to waiting for STX,
// bit_period to 104 and empties the output register.
`include "uart_rx_stx_etx_deframer_macros.svh"

module uart_rx_stx_etx_deframer #(
  parameter int unsigned CNT_W = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  urxd_in_if.sink                       in_ch,
  urxd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [urxd_pkg::PERIOD_W-1:0] cfg_wdata
);
  import urxd_pkg::*;

  logic [PERIOD_W-1:0] bit_period_r;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;
  byte_evt_t           evt;
  frame_res_t          res;
  byte_evt_t           evt_r;
  frame_res_t          res_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      bit_period_r <= cfg_wdata;
    end
  end

  urxd_line_rx #(
    .CNT_W      (CNT_W)
  ) u_line_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .rx_level   (in_ch.rx_level),
    .bit_period (bit_period_r),
    .evt        (evt)
  );

  urxd_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .take_frame (in_ch.take_frame),
    .evt        (evt),
    .res        (res)
  );

  assign out_valid_nxt = accept || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evt_r <= evt;
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_done     = evt_r.done;
  assign out_ch.byte_value    = evt_r.value;
  assign out_ch.data_valid    = res_r.data_valid;
  assign out_ch.frame_start   = res_r.frame_start;
  assign out_ch.frame_end     = res_r.frame_end;
  assign out_ch.frame_pending = res_r.frame_pending;

  `URXD_ASSERT_NEXT(a_accept_gives_result, accept, out_ch.valid, "accepted tick gave no result")
  `URXD_ASSERT_IMP(a_end_leaves_pending, out_ch.valid && out_ch.frame_end, out_ch.frame_pending, "frame end without pending")
  `URXD_ASSERT_IMP(a_payload_is_byte, out_ch.valid && out_ch.data_valid, out_ch.byte_done && !out_ch.frame_start, "payload flag without a plain byte")

endmodule
